// File: rtl/core/awrp_pkg.sv
// shared types and constants for the aged weighted random pick block
`timescale 1ns / 1ps

package awrp_pkg;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int IDX_OUT_W   = 4;
    localparam int CFG_W       = 5;
    localparam int DIV_STEP_W  = 6;
    localparam int OUT_TDATA_W = 40;

    // entry count after reset and the lower bound of the entry count clamp
    localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = 5'd16;
    localparam logic [CFG_W-1:0] ENTRY_COUNT_MIN   = 5'd2;

    // request to the shared remainder unit
    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [DATA_W-1:0]     dividend;
        logic [DATA_W-1:0]     divisor;
    } awrp_div_req_t;

    // status from the shared remainder unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] rem;
    } awrp_div_rsp_t;

endpackage

// File: rtl/core/awrp_stamp_mem.sv
// last-used stamp memory with per-entry valid bits, one write and one registered read port
`timescale 1ns / 1ps

module awrp_stamp_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [awrp_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [awrp_pkg::DATA_W-1:0] rd_data
);

    logic [awrp_pkg::DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            vld_reg;
    logic [awrp_pkg::DATA_W-1:0] rd_mem_reg;
    logic                        rd_vld_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
        rd_vld_reg <= vld_reg[rd_addr];
    end

    // valid bits, cleared at reset so unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

// File: rtl/core/awrp_mod_unit.sv
// shared restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module awrp_mod_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  awrp_pkg::awrp_div_req_t req,
    output awrp_pkg::awrp_div_rsp_t rsp
);

    logic [awrp_pkg::DATA_W-1:0]     dvd_reg;
    logic [awrp_pkg::DATA_W-1:0]     dsr_reg;
    logic [awrp_pkg::DATA_W-1:0]     rem_reg;
    logic [awrp_pkg::DIV_STEP_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [awrp_pkg::DATA_W:0]       shifted;
    logic                            ge;
    logic [awrp_pkg::DATA_W-1:0]     rem_step;

    // one shift, compare and subtract step
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[awrp_pkg::DATA_W-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_step = ge ? awrp_pkg::DATA_W'(shifted - {1'b0, dsr_reg})
                      : shifted[awrp_pkg::DATA_W-1:0];
    end

    // operand and remainder registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[awrp_pkg::DATA_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == awrp_pkg::DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: rtl/core/aged_weighted_random_pick_top.sv
// top level: sequencer for the aged weighted random pick, stamp memory and remainder unit
`timescale 1ns / 1ps

// Each input transaction carries a 32-bit random value and picks a new entry among the
// first entry_count entries (clamped to 2..MAX_ENTRIES), never the current one. An
// entry's weight is the selection counter minus its last-used stamp plus one; the
// random value modulo the total weight selects an entry by running prefix sum. For each
// item a summing pass and a scanning pass read the stamp memory one entry per cycle
// through its single read port, and the shared remainder unit resolves one dividend
// bit per cycle. The input is not ready while an item is in progress; a finished
// result sits in the output register while the next item is taken. Stamps read as
// zero after reset through per-entry valid bits, so no clearing pass is needed.
module aged_weighted_random_pick_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel: entry_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] random_value
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [3:0] chosen_index, [35:4] selection_number, zero pad
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int DW    = awrp_pkg::DATA_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SUM   = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_FBDIV = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [awrp_pkg::CFG_W-1:0]      cfg_count_reg;
    logic [DW-1:0]                   ctr_reg, ctr_next;
    logic [DW-1:0]                   ctrp1_reg, ctrp1_next;
    logic [IDX_W-1:0]                cur_reg, cur_next;
    logic [DW-1:0]                   rnd_reg, rnd_next;
    logic [CNT_W-1:0]                n_reg, n_next;
    logic [DW-1:0]                   acc_reg, acc_next;
    logic [DW-1:0]                   pick_reg, pick_next;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]                p_idx_reg, p_idx_next;
    logic [IDX_W-1:0]                chosen_reg, chosen_next;
    logic                            out_valid_reg, out_valid_next;
    logic [awrp_pkg::IDX_OUT_W-1:0]  out_idx_reg, out_idx_next;
    logic [DW-1:0]                   out_sel_reg, out_sel_next;

    logic [CNT_W-1:0]                eff_count;
    logic                            issue;
    logic                            take;
    logic                            pass_end;
    logic                            out_free;
    logic [DW-1:0]                   rd_data;
    logic [DW-1:0]                   acc_sum;
    logic [IDX_W:0]                  fb_num;
    logic                            mem_wr;
    awrp_pkg::awrp_div_req_t         div_req;
    awrp_pkg::awrp_div_rsp_t         div_rsp;

    // stamp store
    awrp_stamp_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_stamp_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr),
        .wr_addr (chosen_reg),
        .wr_data (ctrp1_reg),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // shared remainder unit
    awrp_mod_unit u_mod_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // clamp the configured count to 2..MAX_ENTRIES
    always_comb
    begin
        priority if (cfg_count_reg < awrp_pkg::ENTRY_COUNT_MIN)
        begin
            eff_count = CNT_W'(2);
        end
        else if (32'(cfg_count_reg) > 32'(MAX_ENTRIES))
        begin
            eff_count = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_count = CNT_W'(cfg_count_reg);
        end
    end

    // pass control and weight accumulation
    assign issue    = (rd_idx_reg < n_reg);
    assign take     = p_vld_reg && (p_idx_reg != cur_reg);
    assign pass_end = !p_vld_reg && (rd_idx_reg == n_reg);
    assign acc_sum  = acc_reg + ctrp1_reg - rd_data;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign fb_num   = {1'b0, cur_reg} + 1'b1;
    assign mem_wr   = (state_reg == ST_WRITE) && out_free;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        ctrp1_next     = ctrp1_reg;
        cur_next       = cur_reg;
        rnd_next       = rnd_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        pick_next      = pick_reg;
        rd_idx_next    = rd_idx_reg;
        p_vld_next     = p_vld_reg;
        p_idx_next     = p_idx_reg;
        chosen_next    = chosen_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_idx_next   = out_idx_reg;
        out_sel_next   = out_sel_reg;
        div_req.start    = 1'b0;
        div_req.steps    = awrp_pkg::DIV_STEP_W'(DW);
        div_req.dividend = rnd_reg;
        div_req.divisor  = acc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rnd_next    = s_axis_tdata;
                    n_next      = eff_count;
                    ctrp1_next  = ctr_reg + 1'b1;
                    rd_idx_next = '0;
                    acc_next    = '0;
                    p_vld_next  = 1'b0;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                p_vld_next = issue;
                p_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (take)
                begin
                    acc_next = acc_sum;
                end
                if (pass_end)
                begin
                    div_req.start = 1'b1;
                    if (acc_reg == '0)
                    begin
                        // zero total: go straight to the fallback entry
                        div_req.steps    = awrp_pkg::DIV_STEP_W'(IDX_W + 1);
                        div_req.dividend = {fb_num, {(DW - IDX_W - 1){1'b0}}};
                        div_req.divisor  = DW'(n_reg);
                        state_next       = ST_FBDIV;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pick_next   = div_rsp.rem;
                    rd_idx_next = '0;
                    acc_next    = '0;
                    p_vld_next  = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                p_vld_next = issue;
                p_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (take)
                begin
                    acc_next = acc_sum;
                end
                if (take && (pick_reg < acc_sum))
                begin
                    chosen_next = p_idx_reg;
                    p_vld_next  = 1'b0;
                    state_next  = ST_WRITE;
                end
                else if (pass_end)
                begin
                    // no hit through wrapped weights: fallback entry
                    div_req.start    = 1'b1;
                    div_req.steps    = awrp_pkg::DIV_STEP_W'(IDX_W + 1);
                    div_req.dividend = {fb_num, {(DW - IDX_W - 1){1'b0}}};
                    div_req.divisor  = DW'(n_reg);
                    state_next       = ST_FBDIV;
                end
            end
            ST_FBDIV:
            begin
                if (div_rsp.done)
                begin
                    chosen_next = div_rsp.rem[IDX_W-1:0];
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    ctr_next       = ctrp1_reg;
                    cur_next       = chosen_reg;
                    out_valid_next = 1'b1;
                    out_idx_next   = awrp_pkg::IDX_OUT_W'(chosen_reg);
                    out_sel_next   = ctrp1_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= awrp_pkg::ENTRY_COUNT_RESET;
            ctr_reg       <= '0;
            cur_reg       <= '0;
            rd_idx_reg    <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            cur_reg       <= cur_next;
            rd_idx_reg    <= rd_idx_next;
            p_vld_reg     <= p_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                cfg_count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ctrp1_reg   <= ctrp1_next;
        rnd_reg     <= rnd_next;
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        pick_reg    <= pick_next;
        p_idx_reg   <= p_idx_next;
        chosen_reg  <= chosen_next;
        out_idx_reg <= out_idx_next;
        out_sel_reg <= out_sel_next;
    end

    // ports
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_sel_reg, out_idx_reg};

    // the new entry always differs from the current one
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (chosen_reg != cur_reg))
        else $error("picked entry equals current entry");

    // the chosen entry lies inside the entries in use
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (CNT_W'(chosen_reg) < n_reg))
        else $error("picked entry beyond entry count");

    // each committed pick advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> (ctr_reg == $past(ctr_reg) + 1'b1))
        else $error("selection counter did not advance");

    // the remainder unit reports completion only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == ST_DIV) || (state_reg == ST_FBDIV)))
        else $error("remainder done outside a divide state");

endmodule
